/* sv/md5trr_pkg.sv */
// ============================================================================
// md5trr_pkg
// Shared constants, types and step tables for the MD5 tail-round reversal.
// ============================================================================
package md5trr_pkg;

    typedef logic [31:0] t_word;
    typedef logic [3:0]  t_word_idx;
    typedef logic [4:0]  t_rot;

    // MD5 initial chaining values.
    localparam t_word INIT_A = 32'h6745_2301;
    localparam t_word INIT_B = 32'hEFCD_AB89;
    localparam t_word INIT_C = 32'h98BA_DCFE;
    localparam t_word INIT_D = 32'h1032_5476;

    // Number of undo steps (MD5 steps 64 down to 50).
    localparam int NUM_STEPS = 15;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_DIGEST_A = 2'd0;
    localparam logic [1:0] REG_DIGEST_B = 2'd1;
    localparam logic [1:0] REG_DIGEST_C = 2'd2;
    localparam logic [1:0] REG_DIGEST_D = 2'd3;

    // Message word used by each undo step.
    function automatic t_word_idx step_word(input logic [3:0] n);
        t_word_idx k;
        case (n)
            4'd0:    k = 4'd9;
            4'd1:    k = 4'd2;
            4'd2:    k = 4'd11;
            4'd3:    k = 4'd4;
            4'd4:    k = 4'd13;
            4'd5:    k = 4'd6;
            4'd6:    k = 4'd15;
            4'd7:    k = 4'd8;
            4'd8:    k = 4'd1;
            4'd9:    k = 4'd10;
            4'd10:   k = 4'd3;
            4'd11:   k = 4'd12;
            4'd12:   k = 4'd5;
            4'd13:   k = 4'd14;
            4'd14:   k = 4'd7;
            default: k = 4'd0;
        endcase
        return k;
    endfunction

    // Right-rotation amount of each undo step; the pattern repeats every four.
    function automatic t_rot step_rot(input logic [1:0] p);
        t_rot s;
        case (p)
            2'd0:    s = 5'd21;
            2'd1:    s = 5'd15;
            2'd2:    s = 5'd10;
            default: s = 5'd6;
        endcase
        return s;
    endfunction

    // Additive constant of each undo step.
    function automatic t_word step_const(input logic [3:0] n);
        t_word c;
        case (n)
            4'd0:    c = 32'heb86_d391;
            4'd1:    c = 32'h2ad7_d2bb;
            4'd2:    c = 32'hbd3a_f235;
            4'd3:    c = 32'hf753_7e82;
            4'd4:    c = 32'h4e08_11a1;
            4'd5:    c = 32'ha301_4314;
            4'd6:    c = 32'hfe2c_e6e0;
            4'd7:    c = 32'h6fa8_7e4f;
            4'd8:    c = 32'h8584_5dd1;
            4'd9:    c = 32'hffef_f47d;
            4'd10:   c = 32'h8f0c_cc92;
            4'd11:   c = 32'h655b_59c3;
            4'd12:   c = 32'hfc93_a039;
            4'd13:   c = 32'hab94_23a7;
            4'd14:   c = 32'h432a_ff97;
            default: c = 32'h0000_0000;
        endcase
        return c;
    endfunction

    // 32-bit rotate right.
    function automatic t_word rotr32(input t_word x, input t_rot s);
        logic [63:0] dbl;
        dbl = {x, x} >> s;
        return dbl[31:0];
    endfunction

endpackage

/* sv/md5_tail_round_reversal_top.sv */
// ============================================================================
// md5_tail_round_reversal_top
// Collects a 16-word MD5 message block and, on the last word, undoes MD5
// steps 64 down to 50 against the configured digest to produce a filter word.
// ============================================================================
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall   | word_index, word_value, last
//  out     | output    | o_out_valid / i_out_stall | filter_value
//  cfg     | input     | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// A word without the last flag is stored and the next word may follow at
// once. A last word runs one memory read to prime, then the fifteen undo
// steps in two halves each (the shared step unit and the single read port
// of the message memory set this), then the hand-off state, ST_DONE.
// Reset is synchronous and active low; it clears control and the digest
// registers but not the message memory. While a result word waits under
// stall, plain words keep loading; a reversal that finishes meanwhile holds
// in its hand-off state, with the input stalled, until the waiting word leaves.
module md5_tail_round_reversal_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Input word channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_word_index,
    input  logic [31:0] i_word_value,
    input  logic        i_last_word,
    // Result word channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_filter_value
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [3:0] LAST_STEP = 4'(md5trr_pkg::NUM_STEPS - 1);

    // Digest registers.
    md5trr_pkg::t_word r_dig_a, r_dig_b, r_dig_c, r_dig_d;

    // Message memory with a registered read port.
    md5trr_pkg::t_word r_mem [16];
    md5trr_pkg::t_word r_rd_data;
    md5trr_pkg::t_word_idx w_rd_idx;

    // Control state.
    logic [1:0] r_state, n_state;
    logic [3:0] r_step, n_step;
    logic       r_phase, n_phase;
    logic       r_out_valid, n_out_valid;

    // Working chaining words and step intermediates.
    md5trr_pkg::t_word r_a, r_b, r_c, r_d, n_a, n_b, n_c, n_d;
    md5trr_pkg::t_word r_t, r_mk, n_t, n_mk;
    md5trr_pkg::t_word r_out_data, n_out_data;

    // Step operands selected by the role rotation.
    md5trr_pkg::t_word w_x, w_y, w_z, w_w, w_f, w_res;

    logic w_in_accept;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_filter_value = r_out_data;

    // Configuration writes; every 2-bit index names a register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dig_a <= '0;
            r_dig_b <= '0;
            r_dig_c <= '0;
            r_dig_d <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                md5trr_pkg::REG_DIGEST_A: r_dig_a <= i_cfg_data;
                md5trr_pkg::REG_DIGEST_B: r_dig_b <= i_cfg_data;
                md5trr_pkg::REG_DIGEST_C: r_dig_c <= i_cfg_data;
                md5trr_pkg::REG_DIGEST_D: r_dig_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The read address runs one step ahead of the step being computed.
    assign w_rd_idx = md5trr_pkg::step_word((r_state == ST_PREP) ? 4'd0 : r_step + 4'd1);

    // Message memory: write on an accepted word, read every cycle.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_mem[i_word_index] <= i_word_value;
        end
        r_rd_data <= r_mem[w_rd_idx];
    end

    // Role rotation: the updated word cycles through B, C, D, A.
    always_comb begin
        case (r_step[1:0])
            2'd0: begin
                w_x = r_b; w_y = r_c; w_z = r_d; w_w = r_a;
            end
            2'd1: begin
                w_x = r_c; w_y = r_d; w_z = r_a; w_w = r_b;
            end
            2'd2: begin
                w_x = r_d; w_y = r_a; w_z = r_b; w_w = r_c;
            end
            default: begin
                w_x = r_a; w_y = r_b; w_z = r_c; w_w = r_d;
            end
        endcase
        w_f   = w_z ^ (w_y | ~w_w);
        w_res = r_t - r_mk;
    end

    // Sequencer and datapath next state.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_t         = r_t;
        n_mk        = r_mk;

        // The waiting result leaves when the consumer takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_accept && i_last_word) begin
                    n_a     = r_dig_a - md5trr_pkg::INIT_A;
                    n_b     = r_dig_b - md5trr_pkg::INIT_B;
                    n_c     = r_dig_c - md5trr_pkg::INIT_C;
                    n_d     = r_dig_d - md5trr_pkg::INIT_D;
                    n_step  = 4'd0;
                    n_phase = 1'b0;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (!r_phase) begin
                    // First half: rotate and subtract I; add word and constant.
                    n_t     = md5trr_pkg::rotr32(w_x - w_y, md5trr_pkg::step_rot(r_step[1:0]))
                              - w_f;
                    n_mk    = r_rd_data + md5trr_pkg::step_const(r_step);
                    n_phase = 1'b1;
                end else begin
                    // Second half: final subtract and write back the target word.
                    case (r_step[1:0])
                        2'd0:    n_b = w_res;
                        2'd1:    n_c = w_res;
                        2'd2:    n_d = w_res;
                        default: n_a = w_res;
                    endcase
                    n_phase = 1'b0;
                    if (r_step == LAST_STEP) begin
                        n_state = ST_DONE;
                    end else begin
                        n_step = r_step + 4'd1;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_d;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_c        <= n_c;
        r_d        <= n_d;
        r_t        <= n_t;
        r_mk       <= n_mk;
        r_out_data <= n_out_data;
    end

endmodule

/* sv/md5trr_checker.sv */
// ============================================================================
// md5trr_checker
// Port-level checks of the MD5 tail-round reversal block, bound to its top.
// ============================================================================
module md5trr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_last_word,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_filter_value
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_filter_value))
        else $error("result word dropped or changed while stalled");

    // A last word starts the reversal, which blocks further input words.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_word |=> o_in_stall)
        else $error("input not stalled after last word");

    // A plain word is only stored, so input stays open.
    a_plain_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_last_word |=> !o_in_stall)
        else $error("input stalled after a plain word");

    // A new result only appears at the end of a reversal.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result word without a reversal");

    // Reset leaves the block idle with no result.
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind md5_tail_round_reversal_top md5trr_checker u_md5trr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_last_word    (i_last_word),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_filter_value (o_filter_value)
);
